/* sv/range_list_stream_selector_defines.svh */
// Assertion macros for the range list stream selector
`ifndef RANGE_LIST_STREAM_SELECTOR_DEFINES_SVH
`define RANGE_LIST_STREAM_SELECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define RLS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RLS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RLS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

/* sv/rls_pkg.sv */
package rls_pkg;
    localparam int MaxRanges = 16;
    localparam int MaxResults = 16;
    localparam int IdxW = $clog2(MaxRanges);
    localparam int CntW = $clog2(MaxRanges + 1);

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_SEAL  = 2'd2,
        CMD_ITEM  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_MERGE_RD,
        ST_MERGE_CMP,
        ST_MERGE_FIN,
        ST_RPT_RD,
        ST_RPT_OUT,
        ST_ITEM_RD,
        ST_ITEM_CMP,
        ST_OUT
    } state_t;

    // Result word as presented on the master side
    typedef struct packed {
        logic        table_full;
        logic        keep;
        logic [63:0] item_index;
        logic        last;
        logic [63:0] merged_end;
        logic [63:0] merged_start;
        logic        kind;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic        take;       // capture input item
        logic        clear;
        logic        load;       // store the held range
        logic        rd_i;       // fetch entry i (sort, report)
        logic        rd_cur;     // fetch the entry under the cursor
        logic        swap;       // exchange entries j and j-1
        logic        sort_next_outer;
        logic        sort_step_back;
        logic        merge_init;
        logic        merge_fold; // widen entry w
        logic        merge_new;  // copy entry i to w+1
        logic        merge_next;
        logic        merge_done;
        logic        rpt_init;
        logic        rpt_next;
        logic        item_adv;   // move cursor forward
        logic        item_done;  // count the item
        logic        set_full;
        logic        set_rpt;
        logic        set_item;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        cmd_t        cmd;
        logic        bad_range;
        logic        full;
        logic        sort_outer_done;
        logic        sort_j_zero;
        logic        sort_gt;
        logic        empty;
        logic        merge_done;
        logic        merge_join;
        logic        merge_wider;
        logic        rpt_done;
        logic        sealed;
        logic        item_scan_done;
        logic        item_past;
    } sts_t;
endpackage

/* sv/rls_ram.sv */
module rls_ram #(
    parameter int Width = 64,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr_a,
    input  logic [$clog2(Depth)-1:0] raddr_b,
    output logic [Width-1:0]         rdata_a,
    output logic [Width-1:0]         rdata_b
);
    logic [Width-1:0] mem [Depth];

    // Write one entry, read two with registered data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule

/* sv/rls_datapath.sv */
module rls_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        in_cmd,
    input  logic [63:0]       in_start,
    input  logic [63:0]       in_end,
    input  logic              invert,
    input  rls_pkg::ctl_t     ctl,
    output rls_pkg::sts_t     sts,
    output rls_pkg::result_t  res
);
    import rls_pkg::*;

    logic [1:0]  cmd_reg;
    logic [63:0] rs_reg, re_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] cursor_reg;
    logic [63:0] item_reg;
    logic        sealed_reg;
    logic [CntW-1:0] i_reg;   // sort outer index / merge read index / report index
    logic [CntW-1:0] j_reg;   // sort inner position
    logic [CntW-1:0] w_reg;   // merge write index
    result_t     res_reg;

    logic [IdxW-1:0] ra_a, ra_b, waddr;
    logic [63:0] s_a, s_b, e_a, e_b, ws, we_d;
    logic        wen;

    // Second write of a swap: sequence through one write per cycle
    logic        swap2_reg;
    logic [63:0] sw_s_reg, sw_e_reg;
    logic [IdxW-1:0] sw_addr_reg;

    rls_ram #(.Width(64), .Depth(MaxRanges)) u_start (
        .aclk(aclk), .we(wen), .waddr(waddr), .wdata(ws),
        .raddr_a(ra_a), .raddr_b(ra_b), .rdata_a(s_a), .rdata_b(s_b));
    rls_ram #(.Width(64), .Depth(MaxRanges)) u_end (
        .aclk(aclk), .we(wen), .waddr(waddr), .wdata(we_d),
        .raddr_a(ra_a), .raddr_b(ra_b), .rdata_a(e_a), .rdata_b(e_b));

    // Read address selection
    always_comb begin
        ra_a = j_reg[IdxW-1:0];
        ra_b = (j_reg == '0) ? '0 : IdxW'(j_reg - 1'b1);
        if (ctl.merge_init || ctl.merge_next || ctl.merge_fold || ctl.merge_new) begin
            ra_a = i_reg[IdxW-1:0];
            ra_b = w_reg[IdxW-1:0];
        end
        // Report reads start at entry 0, then follow i
        if (ctl.rpt_init) begin
            ra_a = '0;
        end else if (ctl.rpt_next || ctl.rd_i) begin
            ra_a = i_reg[IdxW-1:0];
        end
        if (ctl.rd_cur) begin
            ra_a = cursor_reg[IdxW-1:0];
        end
    end

    // Write port: load, swap halves, merge updates
    always_comb begin
        wen = 1'b0;
        waddr = count_reg[IdxW-1:0];
        ws = rs_reg;
        we_d = re_reg;
        if (ctl.load) begin
            wen = 1'b1;
        end else if (swap2_reg) begin
            wen = 1'b1;
            waddr = sw_addr_reg;
            ws = sw_s_reg;
            we_d = sw_e_reg;
        end else if (ctl.swap) begin
            wen = 1'b1;
            waddr = IdxW'(j_reg - 1'b1);
            ws = s_a;
            we_d = e_a;
        end else if (ctl.merge_fold) begin
            // widen entry w only when entry i reaches further
            wen = sts.merge_wider;
            waddr = w_reg[IdxW-1:0];
            ws = s_b;
            we_d = e_a;
        end else if (ctl.merge_new) begin
            wen = 1'b1;
            waddr = IdxW'(w_reg + 1'b1);
            ws = s_a;
            we_d = e_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            cursor_reg <= '0;
            item_reg   <= '0;
            sealed_reg <= 1'b0;
            swap2_reg  <= 1'b0;
        end else begin
            swap2_reg <= ctl.swap;
            if (ctl.clear) begin
                count_reg  <= '0;
                cursor_reg <= '0;
                item_reg   <= '0;
                sealed_reg <= 1'b0;
            end
            if (ctl.load) begin
                count_reg  <= count_reg + 1'b1;
                cursor_reg <= '0;
                sealed_reg <= 1'b0;
            end
            if (ctl.merge_done) begin
                count_reg  <= w_reg + 1'b1;
                sealed_reg <= 1'b1;
            end
            if (ctl.rpt_init && sts.empty) begin
                sealed_reg <= 1'b1;
            end
            if (ctl.item_adv) begin
                cursor_reg <= cursor_reg + 1'b1;
            end
            if (ctl.item_done) begin
                item_reg <= item_reg + 64'd1;
            end
        end
    end

    // Hold the input item, the index registers and the result word
    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            cmd_reg <= in_cmd;
            rs_reg  <= in_start;
            re_reg  <= in_end;
            i_reg   <= CntW'(1);
            j_reg   <= CntW'(1);
        end
        if (ctl.swap) begin
            sw_s_reg    <= s_b;
            sw_e_reg    <= e_b;
            sw_addr_reg <= j_reg[IdxW-1:0];
        end
        if (ctl.sort_step_back) begin
            j_reg <= j_reg - 1'b1;
        end
        if (ctl.sort_next_outer) begin
            i_reg <= i_reg + 1'b1;
            j_reg <= i_reg + 1'b1;
        end
        if (ctl.merge_init) begin
            i_reg <= CntW'(1);
            w_reg <= '0;
        end
        if (ctl.merge_fold) begin
            i_reg <= i_reg + 1'b1;
        end
        if (ctl.merge_new) begin
            i_reg <= i_reg + 1'b1;
            w_reg <= w_reg + 1'b1;
        end
        if (ctl.rpt_init) begin
            i_reg <= '0;
        end
        if (ctl.rpt_next) begin
            i_reg <= i_reg + 1'b1;
        end
        if (ctl.set_full || ctl.set_rpt || ctl.set_item) begin
            res_reg <= '0;
            if (ctl.set_full) begin
                res_reg.table_full <= 1'b1;
            end
            if (ctl.set_rpt) begin
                res_reg.merged_start <= s_a;
                res_reg.merged_end   <= e_a;
                res_reg.last <= (i_reg + 1'b1 == count_reg)
                    || (i_reg + 1'b1 == CntW'(MaxResults));
            end
            if (ctl.set_item) begin
                res_reg.kind       <= 1'b1;
                res_reg.item_index <= item_reg;
                res_reg.keep <= invert ^ (sealed_reg && !sts.item_scan_done
                    && item_reg <= e_a && item_reg >= s_a);
            end
        end
    end

    // Status towards the controller
    always_comb begin
        sts.cmd = cmd_t'(cmd_reg);
        sts.bad_range = rs_reg > re_reg;
        sts.full = count_reg >= CntW'(MaxRanges);
        sts.sort_outer_done = i_reg >= count_reg;
        sts.sort_j_zero = j_reg == '0;
        sts.sort_gt = s_b > s_a;
        sts.empty = count_reg == '0;
        sts.merge_done = i_reg >= count_reg;
        sts.merge_join = (s_a == 64'd0) || (s_a - 64'd1 <= e_b);
        sts.merge_wider = e_a > e_b;
        sts.rpt_done = (i_reg >= count_reg) || (i_reg >= CntW'(MaxResults));
        sts.sealed = sealed_reg;
        sts.item_scan_done = cursor_reg >= count_reg;
        sts.item_past = item_reg > e_a;
    end

    assign res = res_reg;
endmodule

/* sv/rls_ctrl.sv */
module rls_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  rls_pkg::sts_t sts,
    output rls_pkg::ctl_t ctl
);
    import rls_pkg::*;

    state_t state_reg, state_next;
    logic   rpt_reg, rpt_next;   // result is a range report

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rpt_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            rpt_reg   <= rpt_next;
        end
    end

    // Sequence each command
    always_comb begin
        state_next = state_reg;
        rpt_next = rpt_reg;
        ctl = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.take = 1'b1;
                    state_next = ST_SORT_RD;
                    rpt_next = 1'b0;
                end
            end
            ST_SORT_RD: begin
                // first cycle after take: dispatch on command
                case (sts.cmd)
                    CMD_CLEAR: begin
                        ctl.clear = 1'b1;
                        state_next = ST_IDLE;
                    end
                    CMD_LOAD: begin
                        if (sts.bad_range) begin
                            state_next = ST_IDLE;
                        end else if (sts.full) begin
                            ctl.set_full = 1'b1;
                            state_next = ST_OUT;
                        end else begin
                            ctl.load = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    CMD_SEAL: begin
                        state_next = sts.sort_outer_done ? ST_MERGE_RD : ST_SORT_CMP;
                    end
                    default: begin
                        ctl.item_adv = 1'b0;
                        state_next = ST_ITEM_RD;
                    end
                endcase
                if (sts.cmd == CMD_SEAL && !sts.sort_outer_done) begin
                    ctl.rd_i = 1'b1;
                end
            end
            ST_SORT_CMP: begin
                // read data for j and j-1 is valid here
                if (!sts.sort_j_zero && sts.sort_gt) begin
                    ctl.swap = 1'b1;
                    ctl.sort_step_back = 1'b1;
                    state_next = ST_MERGE_FIN;
                end else begin
                    ctl.sort_next_outer = 1'b1;
                    state_next = ST_MERGE_FIN;
                end
            end
            ST_MERGE_FIN: begin
                // let the second swap write land, then re-read
                if (sts.sort_outer_done) begin
                    ctl.merge_init = 1'b1;
                    state_next = sts.empty ? ST_RPT_RD : ST_MERGE_CMP;
                end else begin
                    state_next = ST_SORT_CMP;
                end
            end
            ST_MERGE_RD: begin
                ctl.merge_init = 1'b1;
                state_next = sts.empty ? ST_RPT_RD : ST_MERGE_CMP;
            end
            ST_MERGE_CMP: begin
                ctl.merge_next = 1'b1;
                if (sts.merge_done) begin
                    ctl.merge_done = 1'b1;
                    state_next = ST_RPT_RD;
                end else begin
                    state_next = ST_ITEM_CMP;
                end
            end
            ST_ITEM_CMP: begin
                if (!sts.cmd[0]) begin
                    // merge step with entries i and w read; fold or open a new entry
                    if (sts.merge_join) begin
                        ctl.merge_fold = 1'b1;
                    end else begin
                        ctl.merge_new = 1'b1;
                    end
                    state_next = ST_MERGE_CMP;
                end else begin
                    // item scan with cursor entry read
                    if (!sts.sealed || sts.item_scan_done || !sts.item_past) begin
                        ctl.set_item = 1'b1;
                        ctl.item_done = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        ctl.item_adv = 1'b1;
                        state_next = ST_ITEM_RD;
                    end
                end
            end
            ST_ITEM_RD: begin
                ctl.rd_cur = 1'b1;
                state_next = ST_ITEM_CMP;
            end
            ST_RPT_RD: begin
                ctl.rpt_init = 1'b1;
                rpt_next = 1'b1;
                state_next = ST_RPT_OUT;
            end
            ST_RPT_OUT: begin
                ctl.rpt_next = 1'b0;
                if (sts.rpt_done) begin
                    state_next = ST_IDLE;
                end else begin
                    ctl.set_rpt = 1'b1;
                    ctl.rpt_next = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                // keep the next report entry on the read port
                if (rpt_reg) begin
                    ctl.rd_i = 1'b1;
                end
                if (m_ready) begin
                    state_next = rpt_reg ? ST_RPT_OUT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

/* sv/range_list_stream_selector.sv */
// Range list stream selector. Commands arrive on s_axis: clear, load a range,
// seal, or present one stream item. An item's verdict is offered on m_axis
// once the forward-only cursor has scanned past the merged ranges that end
// before the item; the cursor scan through the range table (one RAM read per
// step) sets when this happens. Seal sorts the table by insertion sort,
// merges it, then reports each merged range on m_axis (kind 0, last on the
// final report). A full table answers a load with a table_full result. No
// clearing pass.
module range_list_stream_selector (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         invert_we,
    input  logic         invert_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // range_start [63:0], range_end [127:64]
    input  logic [1:0]   s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata,  // merged_start, merged_end, item_index,
                                        // keep, table_full, zero fill
    output logic         m_axis_tuser,  // kind
    output logic         m_axis_tlast   // last
);
    import rls_pkg::*;

    `include "range_list_stream_selector_defines.svh"

    logic    invert_reg;
    ctl_t    ctl;
    sts_t    sts;
    result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= 1'b0;
        end else if (invert_we) begin
            invert_reg <= invert_wdata;
        end
    end

    rls_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_cmd(s_axis_tuser), .in_start(s_axis_tdata[63:0]),
        .in_end(s_axis_tdata[127:64]), .invert(invert_reg),
        .ctl(ctl), .sts(sts), .res(res));

    rls_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
        .sts(sts), .ctl(ctl));

    // Pack the result
    assign m_axis_tdata = {6'd0, res.table_full, res.keep, res.item_index,
                           res.merged_end, res.merged_start};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

    `RLS_ASSERT_IMPL(a_no_take_busy, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `RLS_ASSERT_IMPL(a_full_kind, aclk, aresetn, m_axis_tvalid && res.table_full, !res.kind)
    `RLS_ASSERT_NEXT(a_take_busy, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rls_pkg::*;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic KIND_RANGE = 1'b0;
    localparam logic KIND_ITEM  = 1'b1;
    localparam int LIMIT_CYCLES = 400000;

    // Expected output word of the selector
    typedef struct {
        logic        kind;
        logic [63:0] mstart;
        logic [63:0] mend;
        logic        last;
        logic [63:0] index;
        logic        keep;
        logic        full;
    } verdict_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Selector model and queue of expected outputs
    class selector_scoreboard;
        logic [63:0] starts[MaxRanges];
        logic [63:0] ends[MaxRanges];
        int          count;
        int          cursor;
        logic [63:0] item_no;
        bit          sealed;
        bit          invert;
        verdict_t    pending[$];

        function void clear_all();
            count = 0; cursor = 0; item_no = '0; sealed = 0; invert = 0;
            pending.delete();
        endfunction

        function void push(logic kind, logic [63:0] ms, logic [63:0] me, logic lst,
                           logic [63:0] idx, logic kp, logic fl);
            verdict_t v;
            v.kind = kind; v.mstart = ms; v.mend = me; v.last = lst;
            v.index = idx; v.keep = kp; v.full = fl;
            pending.insert(pending.size(), v);
        endfunction

        // Sort by start, then fold overlapping or touching neighbours
        function void normalise();
            logic [63:0] s, e;
            int j, w;
            for (int i = 1; i < count; i++) begin
                s = starts[i]; e = ends[i]; j = i;
                while (j > 0 && starts[j-1] > s) begin
                    starts[j] = starts[j-1]; ends[j] = ends[j-1]; j--;
                end
                starts[j] = s; ends[j] = e;
            end
            if (count == 0) return;
            w = 0;
            for (int i = 1; i < count; i++) begin
                s = starts[i];
                if (s == 64'd0 || s - 64'd1 <= ends[w]) begin
                    if (ends[i] > ends[w]) ends[w] = ends[i];
                end else begin
                    w++; starts[w] = s; ends[w] = ends[i];
                end
            end
            count = w + 1;
        endfunction

        function bit selected(logic [63:0] idx);
            for (int i = cursor; i < count; i++) begin
                if (idx > ends[i]) cursor = i + 1;
                else return idx >= starts[i];
            end
            return 0;
        endfunction

        function void note_input(cmd_t cmd, logic [63:0] rs, logic [63:0] re);
            int n;
            bit sel;
            case (cmd)
                CMD_CLEAR: begin
                    count = 0; cursor = 0; item_no = '0; sealed = 0;
                end
                CMD_LOAD: begin
                    if (rs <= re) begin
                        if (count >= MaxRanges) begin
                            push(KIND_RANGE, '0, '0, 1'b0, '0, 1'b0, 1'b1);
                        end else begin
                            starts[count] = rs; ends[count] = re; count++;
                            sealed = 0; cursor = 0;
                        end
                    end
                end
                CMD_SEAL: begin
                    normalise();
                    sealed = 1;
                    n = count < MaxResults ? count : MaxResults;
                    for (int i = 0; i < n; i++)
                        push(KIND_RANGE, starts[i], ends[i], i + 1 == n, '0, 1'b0, 1'b0);
                end
                default: begin
                    sel = sealed ? selected(item_no) : 1'b0;
                    push(KIND_ITEM, '0, '0, 1'b0, item_no, sel ^ invert, 1'b0);
                    item_no = item_no + 64'd1;
                end
            endcase
        endfunction

        task check_output(logic [199:0] data, logic kind, logic lst);
            verdict_t v;
            if (pending.size() == 0) begin
                report_mismatch("unexpected output", data[63:0], '0);
                return;
            end
            v = pending.pop_front();
            if (kind !== v.kind) report_mismatch("kind", 64'(kind), 64'(v.kind));
            if (data[63:0] !== v.mstart) report_mismatch("merged_start", data[63:0], v.mstart);
            if (data[127:64] !== v.mend) report_mismatch("merged_end", data[127:64], v.mend);
            if (lst !== v.last) report_mismatch("last", 64'(lst), 64'(v.last));
            if (data[191:128] !== v.index)
                report_mismatch("item_index", data[191:128], v.index);
            if (data[192] !== v.keep) report_mismatch("keep", 64'(data[192]), 64'(v.keep));
            if (data[193] !== v.full)
                report_mismatch("table_full", 64'(data[193]), 64'(v.full));
            if (data[199:194] !== 6'd0)
                report_mismatch("zero fill", 64'(data[199:194]), '0);
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         invert_we = 0;
    logic         invert_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [199:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    range_list_stream_selector uut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    selector_scoreboard board = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_off = 0;
    longint cycles = 0;

    // Timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver: random stalls, plus an optional long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one command and wait for its transfer; valid drops only while idling
    task automatic send_cmd(cmd_t cmd, logic [63:0] rs, logic [63:0] re);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {re, rs};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        board.note_input(cmd, rs, re);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_invert(bit value);
        drain();
        invert_we <= 1;
        invert_wdata <= value;
        @(posedge aclk);
        board.invert = value;
        invert_we <= 0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Small ranges so that items often land inside them
    task automatic random_sequence();
        logic [63:0] s, e;
        int nload;
        send_cmd(CMD_CLEAR, rand64(), rand64());
        nload = ($urandom_range(9) == 0) ? 18 : $urandom_range(1, 6);
        for (int i = 0; i < nload; i++) begin
            s = 64'($urandom_range(40));
            e = s + 64'($urandom_range(6));
            case ($urandom_range(9))
                0: e = ALL_ONES;
                1: begin s = rand64(); e = rand64(); end
                default: ;
            endcase
            send_cmd(CMD_LOAD, s, e);
        end
        if ($urandom_range(5) != 0) send_cmd(CMD_SEAL, rand64(), rand64());
        for (int i = $urandom_range(4, 14); i > 0; i--)
            send_cmd($urandom_range(7) == 0 ? cmd_t'($urandom_range(3)) : CMD_ITEM,
                     rand64(), rand64());
    endtask

    initial begin
        board.clear_all();
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: item before seal, inverted and open ranges, touching ranges
        send_cmd(CMD_ITEM, 64'd0, 64'd0);
        send_cmd(CMD_SEAL, 64'd0, 64'd0);
        send_cmd(CMD_LOAD, 64'd10, 64'd5);
        send_cmd(CMD_LOAD, 64'd5, 64'd7);
        send_cmd(CMD_LOAD, 64'd0, 64'd2);
        send_cmd(CMD_LOAD, 64'd3, 64'd3);
        send_cmd(CMD_LOAD, 64'd100, ALL_ONES);
        send_cmd(CMD_SEAL, ALL_ONES, ALL_ONES);
        send_cmd(CMD_SEAL, 64'd0, 64'd0);
        for (int i = 0; i < 5; i++) send_cmd(CMD_ITEM, ALL_ONES, 64'd0);
        send_cmd(CMD_LOAD, 64'd9, 64'd9);
        send_cmd(CMD_ITEM, 64'd0, 64'd0);
        send_cmd(CMD_CLEAR, 64'd0, 64'd0);
        // Fill table past full, disjoint ranges give a long report
        for (int i = 0; i < 17; i++)
            send_cmd(CMD_LOAD, 64'(3 * (16 - i)), 64'(3 * (16 - i)));
        send_cmd(CMD_SEAL, 64'd0, 64'd0);
        write_invert(1);
        send_cmd(CMD_ITEM, 64'd0, 64'd0);
        write_invert(0);

        // Random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 72 : (ph == 3) ? 29 : 0;
            recv_stall_pct = (ph == 2) ? 72 : (ph == 3) ? 29 : 0;
            write_invert(ph[0]);
            for (int k = 0; k < 3; k++) random_sequence();
            if (ph == 0) begin
                // Long receiver hold-off while items keep coming
                hold_off = 400;
                random_sequence();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_invert(1);
        drain();
        if (errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
